[rtl/core/running_value_error_statistics_core_assert.svh]
// assertion macros for the running statistics core
`ifndef RUNNING_VALUE_ERROR_STATISTICS_CORE_ASSERT_SVH
`define RUNNING_VALUE_ERROR_STATISTICS_CORE_ASSERT_SVH

// property that must hold in the cycle after a condition
`define RVS_ASSERT_NEXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("assertion failed");

// property that must hold in the same cycle
`define RVS_ASSERT_NOW(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("assertion failed");

`endif

[rtl/core/rvstat_pkg.sv]
// ----------------------------------------------------------------------------
// rvstat_pkg
// types and constants shared by the running statistics core
// ----------------------------------------------------------------------------
package rvstat_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int COUNT_BITS  = 24;
	localparam int SQ_BITS     = 2 * SAMPLE_BITS + COUNT_BITS;
	localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
	localparam int DIV_BITS    = SQ_BITS;

	localparam logic KIND_ACC    = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	typedef struct packed {
		logic                          kind;
		logic signed [SAMPLE_BITS-1:0] q_value;
		logic signed [SAMPLE_BITS-1:0] q_error;
	} in_item_t;

	typedef struct packed {
		logic [15:0]        rms_error;
		logic signed [15:0] mean_value;
		logic [15:0]        std_value;
		logic signed [15:0] min_value;
		logic signed [15:0] max_value;
		logic [23:0]        sample_count;
		logic               empty_res;
		logic               saturated;
	} out_item_t;

	// snapshot handed from front to back on a report
	typedef struct packed {
		logic [COUNT_BITS-1:0]         n;
		logic [SQ_BITS-1:0]            err_sq;
		logic [SUM_BITS-1:0]           vsum;
		logic [SQ_BITS-1:0]            val_sq;
		logic signed [SAMPLE_BITS-1:0] vmin;
		logic signed [SAMPLE_BITS-1:0] vmax;
		logic                          dropped;
	} snap_t;

endpackage

[rtl/core/rvstat_front.sv]
// ----------------------------------------------------------------------------
// rvstat_front
// accumulates each sample as it is taken and snapshots them on a report
// ----------------------------------------------------------------------------
module rvstat_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  rvstat_pkg::in_item_t in_item,
	output logic                 snap_valid,
	input  logic                 snap_full,
	output rvstat_pkg::snap_t    snap
);

	localparam logic [rvstat_pkg::COUNT_BITS-1:0] CMAX = '1;
	localparam logic signed [rvstat_pkg::SAMPLE_BITS-1:0] SMAX =
		{1'b0, {(rvstat_pkg::SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [rvstat_pkg::SAMPLE_BITS-1:0] SMIN =
		{1'b1, {(rvstat_pkg::SAMPLE_BITS-1){1'b0}}};

	logic [rvstat_pkg::COUNT_BITS-1:0]          n_q;
	logic [rvstat_pkg::SQ_BITS-1:0]             err_sq_q;
	logic [rvstat_pkg::SUM_BITS-1:0]            vsum_q;
	logic [rvstat_pkg::SQ_BITS-1:0]             val_sq_q;
	logic signed [rvstat_pkg::SAMPLE_BITS-1:0]  min_q;
	logic signed [rvstat_pkg::SAMPLE_BITS-1:0]  max_q;
	logic                                       drop_q;
	logic [2*rvstat_pkg::SAMPLE_BITS-1:0]       e_sq;
	logic [2*rvstat_pkg::SAMPLE_BITS-1:0]       v_sq;
	logic                                       accept;

	// report waits until the queue has room
	assign full   = (in_item.kind == rvstat_pkg::KIND_REPORT) && snap_full;
	assign accept = push && !full;
	assign snap_valid = accept && (in_item.kind == rvstat_pkg::KIND_REPORT);

	assign e_sq = (2*rvstat_pkg::SAMPLE_BITS)'($signed(in_item.q_error) *
		$signed(in_item.q_error));
	assign v_sq = (2*rvstat_pkg::SAMPLE_BITS)'($signed(in_item.q_value) *
		$signed(in_item.q_value));

	always_comb begin
		snap.n       = n_q;
		snap.err_sq  = err_sq_q;
		snap.vsum    = vsum_q;
		snap.val_sq  = val_sq_q;
		snap.vmin    = min_q;
		snap.vmax    = max_q;
		snap.dropped = drop_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q      <= '0;
			err_sq_q <= '0;
			vsum_q   <= '0;
			val_sq_q <= '0;
			min_q    <= SMAX;
			max_q    <= SMIN;
			drop_q   <= 1'b0;
		end else if (accept) begin
			if (in_item.kind == rvstat_pkg::KIND_REPORT) begin
				n_q      <= '0;
				err_sq_q <= '0;
				vsum_q   <= '0;
				val_sq_q <= '0;
				min_q    <= SMAX;
				max_q    <= SMIN;
				drop_q   <= 1'b0;
			end else if (n_q == CMAX) begin
				drop_q <= 1'b1;
			end else begin
				n_q      <= n_q + 1'b1;
				err_sq_q <= err_sq_q + rvstat_pkg::SQ_BITS'(e_sq);
				val_sq_q <= val_sq_q + rvstat_pkg::SQ_BITS'(v_sq);
				vsum_q   <= vsum_q + rvstat_pkg::SUM_BITS'(in_item.q_value);
				if (in_item.q_value < min_q) min_q <= in_item.q_value;
				if (in_item.q_value > max_q) max_q <= in_item.q_value;
			end
		end
	end

endmodule

[rtl/core/rvstat_queue.sv]
// ----------------------------------------------------------------------------
// rvstat_queue
// two-entry queue of report snapshots between front and back
// ----------------------------------------------------------------------------
module rvstat_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  rvstat_pkg::snap_t wr_data,
	output logic              q_full,
	output logic              q_valid,
	input  logic              rd,
	output rvstat_pkg::snap_t rd_data
);

	rvstat_pkg::snap_t mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign q_full  = cnt_q == 2'd2;
	assign q_valid = cnt_q != 2'd0;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

endmodule

[rtl/core/rvstat_back.sv]
// ----------------------------------------------------------------------------
// rvstat_back
// sequential divider and square root unit that builds one report
// ----------------------------------------------------------------------------
module rvstat_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  rvstat_pkg::snap_t     snap,
	output logic                  q_rd,
	output logic                  res_valid,
	input  logic                  res_pop,
	output rvstat_pkg::out_item_t res
);

	localparam int DW = rvstat_pkg::DIV_BITS;
	localparam int RW = DW / 2;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DIVE  = 4'd1;
	localparam logic [3:0] ST_SQRTE = 4'd2;
	localparam logic [3:0] ST_DIVM  = 4'd3;
	localparam logic [3:0] ST_MSQ   = 4'd4;
	localparam logic [3:0] ST_DIVS  = 4'd5;
	localparam logic [3:0] ST_SQRTS = 4'd6;
	localparam logic [3:0] ST_DONE  = 4'd7;

	logic [3:0]    state_q;
	logic [6:0]    step_q;
	rvstat_pkg::snap_t s_q;
	// shared long-division registers
	logic [DW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	// shared square root registers
	logic [DW+1:0] srem_q;
	logic [RW-1:0] root_q;
	logic [DW-1:0] rad_q;
	logic [15:0]   rms_q;
	logic [15:0]   mq_q;
	logic          mneg_q;
	logic [DW-1:0] msq_q;
	logic [DW-1:0] varq_q;
	logic          out_v_q;
	rvstat_pkg::out_item_t out_q;

	logic [DW:0]   rem_sh;
	logic [DW:0]   rem_try;
	logic [DW+1:0] srem_sh;
	logic [DW+1:0] s_try;
	logic [rvstat_pkg::SUM_BITS-1:0] vmag;
	logic          busy_start;

	assign vmag = s_q.vsum[rvstat_pkg::SUM_BITS-1] ? -s_q.vsum : s_q.vsum;
	assign rem_sh  = {rem_q, quo_q[DW-1]};
	assign rem_try = rem_sh - {{(DW+1-rvstat_pkg::COUNT_BITS){1'b0}}, s_q.n};
	assign srem_sh = {srem_q[DW-1:0], rad_q[DW-1:DW-2]};
	assign s_try   = srem_sh - {{2{1'b0}}, root_q, 2'b01};

	assign busy_start = (state_q == ST_IDLE) && q_valid;
	assign q_rd       = busy_start;
	assign res_valid  = out_v_q;
	assign res        = out_q;

	always_ff @(posedge clk) begin
		if (busy_start) s_q <= snap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			out_v_q <= 1'b0;
			quo_q   <= '0;
			rem_q   <= '0;
			srem_q  <= '0;
			root_q  <= '0;
			rad_q   <= '0;
			rms_q   <= '0;
			mq_q    <= '0;
			mneg_q  <= 1'b0;
			msq_q   <= '0;
			varq_q  <= '0;
			out_q   <= '0;
		end else begin
			if (out_v_q && res_pop) out_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (busy_start) begin
						state_q <= ST_DIVE;
						step_q  <= '0;
						rem_q   <= '0;
						quo_q   <= snap.err_sq;
					end
				end
				ST_DIVE, ST_DIVM, ST_DIVS: begin
					if (s_q.n == '0) begin
						state_q <= ST_DONE;
					end else begin
						if (!rem_try[DW]) begin
							rem_q <= rem_try[DW-1:0];
							quo_q <= {quo_q[DW-2:0], 1'b1};
						end else begin
							rem_q <= rem_sh[DW-1:0];
							quo_q <= {quo_q[DW-2:0], 1'b0};
						end
						step_q <= step_q + 1'b1;
						if (step_q == 7'(DW-1)) begin
							step_q <= '0;
							if (state_q == ST_DIVE) begin
								state_q <= ST_SQRTE;
								rad_q   <= {quo_q[DW-2:0], !rem_try[DW]};
								srem_q  <= '0;
								root_q  <= '0;
							end else if (state_q == ST_DIVM) begin
								state_q <= ST_MSQ;
								mq_q    <= 16'({quo_q[DW-2:0], !rem_try[DW]});
								msq_q   <= DW'({quo_q[DW-2:0], !rem_try[DW]});
								mneg_q  <= s_q.vsum[rvstat_pkg::SUM_BITS-1];
							end else begin
								state_q <= ST_SQRTS;
								rad_q   <= ({quo_q[DW-2:0], !rem_try[DW]} > msq_q) ?
									{quo_q[DW-2:0], !rem_try[DW]} - msq_q : '0;
								srem_q  <= '0;
								root_q  <= '0;
							end
						end
					end
				end
				ST_MSQ: begin
					// quotient is below 2^40, square in one multiply of the mean
					msq_q   <= DW'(msq_q[27:0] * msq_q[27:0]);
					state_q <= ST_DIVS;
					rem_q   <= '0;
					quo_q   <= s_q.val_sq;
				end
				ST_SQRTE, ST_SQRTS: begin
					rad_q <= {rad_q[DW-3:0], 2'b00};
					if (!s_try[DW+1]) begin
						srem_q <= s_try;
						root_q <= {root_q[RW-2:0], 1'b1};
					end else begin
						srem_q <= srem_sh;
						root_q <= {root_q[RW-2:0], 1'b0};
					end
					step_q <= step_q + 1'b1;
					if (step_q == 7'(RW-1)) begin
						step_q <= '0;
						if (state_q == ST_SQRTE) begin
							rms_q   <= 16'({root_q[RW-2:0], !s_try[DW+1]});
							state_q <= ST_DIVM;
							rem_q   <= '0;
							quo_q   <= DW'(vmag);
						end else begin
							varq_q  <= DW'({root_q[RW-2:0], !s_try[DW+1]});
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (!out_v_q) begin
						out_v_q <= 1'b1;
						out_q.sample_count <= 24'(s_q.n);
						out_q.empty_res    <= s_q.n == '0;
						out_q.saturated    <= s_q.dropped;
						if (s_q.n == '0) begin
							out_q.rms_error  <= '0;
							out_q.mean_value <= '0;
							out_q.std_value  <= '0;
							out_q.min_value  <= '0;
							out_q.max_value  <= '0;
						end else begin
							out_q.rms_error  <= rms_q;
							out_q.mean_value <= mneg_q ? -mq_q : mq_q;
							out_q.std_value  <= varq_q[15:0];
							out_q.min_value  <= 16'(s_q.vmin);
							out_q.max_value  <= 16'(s_q.vmax);
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/running_value_error_statistics_core.sv]
// ----------------------------------------------------------------------------
// running_value_error_statistics_core
// running rms error, mean, deviation, min and max of a sample stream
// ----------------------------------------------------------------------------
// channel  direction  handshake          payload
// in       to core    push / full        rvstat_pkg::in_item_t
// res      from core  pop / empty        rvstat_pkg::out_item_t
//
// a sample transaction is taken every cycle and accumulated in that cycle
// a report is snapshotted into a two-entry queue and cleared at once
// the back end builds one report at a time with the bit-serial divider and
// square root unit, reading the next snapshot only when idle
// full rises only for a report while the queue holds two reports
// reset is asynchronous and leaves every accumulator cleared
module running_value_error_statistics_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  rvstat_pkg::in_item_t  in_item,
	output logic                  empty,
	input  logic                  pop,
	output rvstat_pkg::out_item_t res_item
);

	`include "running_value_error_statistics_core_assert.svh"

	logic              snap_valid;
	logic              q_full;
	logic              q_valid;
	logic              q_rd;
	logic              res_valid;
	rvstat_pkg::snap_t snap_in;
	rvstat_pkg::snap_t snap_out;

	rvstat_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.in_item    (in_item),
		.snap_valid (snap_valid),
		.snap_full  (q_full),
		.snap       (snap_in)
	);

	rvstat_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (snap_valid),
		.wr_data (snap_in),
		.q_full  (q_full),
		.q_valid (q_valid),
		.rd      (q_rd),
		.rd_data (snap_out)
	);

	rvstat_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.snap      (snap_out),
		.q_rd      (q_rd),
		.res_valid (res_valid),
		.res_pop   (pop),
		.res       (res_item)
	);

	assign empty = !res_valid;

	`RVS_ASSERT_NOW(a_no_write_when_full, snap_valid, !q_full)
	`RVS_ASSERT_NOW(a_read_needs_data, q_rd, q_valid)
	`RVS_ASSERT_NOW(a_empty_flag_zero, !empty && res_item.empty_res,
		res_item.sample_count == '0 && res_item.rms_error == '0)

endmodule

[sim/running_value_error_statistics_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// running_value_error_statistics_core_tb
// self-checking bench for the running statistics core: a directed table
// followed by random sample streams and reports, every report transaction
// compared field by field with a behavioural model of the accumulators
// ----------------------------------------------------------------------------
module running_value_error_statistics_core_tb;

	localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;

	typedef struct {
		rvstat_pkg::in_item_t  item;
		logic                  known;
		rvstat_pkg::out_item_t res;
	} row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	rvstat_pkg::in_item_t  in_item;
	logic                  empty;
	logic                  pop;
	rvstat_pkg::out_item_t res_item;

	rvstat_pkg::out_item_t report_q[$];
	int                    errors;

	logic [23:0]        m_count;
	logic [63:0]        m_err_sq;
	logic [63:0]        m_vsum;
	logic [63:0]        m_val_sq;
	logic signed [15:0] m_min;
	logic signed [15:0] m_max;
	logic               m_dropped;

	row_t dir_rows[$];

	running_value_error_statistics_core DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.empty(empty), .pop(pop), .res_item(res_item)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#500ms;
		$display("Verification failed");
		$finish;
	end

	function automatic logic [63:0] floor_sqrt(logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		r = '0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	task automatic clear_stats();
		m_count   = '0;
		m_err_sq  = '0;
		m_vsum    = '0;
		m_val_sq  = '0;
		m_min     = 16'sh7FFF;
		m_max     = 16'sh8000;
		m_dropped = 1'b0;
	endtask

	task automatic apply_item(rvstat_pkg::in_item_t it);
		logic signed [63:0]    v;
		logic signed [63:0]    e;
		logic [63:0]           n;
		logic [63:0]           mag;
		logic [63:0]           q;
		logic [63:0]           sq;
		logic                  neg;
		rvstat_pkg::out_item_t r;
		v = 64'(it.q_value);
		e = 64'(it.q_error);
		if (it.kind == rvstat_pkg::KIND_ACC) begin
			if (m_count == COUNT_MAX) begin
				m_dropped = 1'b1;
			end else begin
				m_count  = m_count + 24'd1;
				m_err_sq = m_err_sq + e * e;
				m_vsum   = m_vsum + v;
				m_val_sq = m_val_sq + v * v;
				if (it.q_value < m_min) m_min = it.q_value;
				if (it.q_value > m_max) m_max = it.q_value;
			end
		end else begin
			r = '0;
			n = 64'(m_count);
			if (n != 0) begin
				neg = m_vsum[63];
				mag = neg ? -m_vsum : m_vsum;
				q   = (mag / n) & ((64'd1 << 62) - 64'd1);
				r.mean_value = neg ? -q[15:0] : q[15:0];
				r.rms_error  = 16'(floor_sqrt(m_err_sq / n));
				sq = m_val_sq / n;
				r.std_value  = (sq > q * q) ? 16'(floor_sqrt(sq - q * q)) : 16'd0;
				r.min_value  = m_min;
				r.max_value  = m_max;
			end
			r.sample_count = m_count;
			r.empty_res    = (n == 0);
			r.saturated    = m_dropped;
			report_q.push_back(r);
			clear_stats();
		end
	endtask

	task automatic send(rvstat_pkg::in_item_t it);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
			(($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push    <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (full) @(posedge clk);
		apply_item(it);
	endtask

	function automatic rvstat_pkg::in_item_t mk(logic k, logic [15:0] v, logic [15:0] e);
		rvstat_pkg::in_item_t it;
		it.kind    = k;
		it.q_value = v;
		it.q_error = e;
		return it;
	endfunction

	task automatic add_row(rvstat_pkg::in_item_t it, logic known, rvstat_pkg::out_item_t r);
		row_t rw;
		rw.item  = it;
		rw.known = known;
		rw.res   = r;
		dir_rows.push_back(rw);
	endtask

	// result side: random stalls, compare against the oldest report
	initial begin
		rvstat_pkg::out_item_t exp_r;
		int                    stall;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) :
				$urandom_range(0, 2);
			if ($urandom_range(0, 3) == 0) stall = 0;
			if (stall != 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			if (report_q.size() == 0) begin
				$display("%0t unexpected report transaction: actual %p", $time, res_item);
				errors++;
			end else begin
				exp_r = report_q.pop_front();
				if (res_item !== exp_r) begin
					$display("%0t report mismatch: expected %p actual %p",
						$time, exp_r, res_item);
					errors++;
				end
			end
		end
	end

	initial begin
		rvstat_pkg::out_item_t r;
		rvstat_pkg::in_item_t  it;
		int                    sent;
		int                    burst;
		errors    = 0;
		arst_n    = 1'b0;
		push      = 1'b0;
		in_item   = '0;
		clear_stats();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty report after reset
		r = '0;
		r.empty_res = 1'b1;
		add_row(mk(rvstat_pkg::KIND_REPORT, 16'h1234, 16'h5678), 1'b1, r);
		// single extreme sample
		add_row(mk(rvstat_pkg::KIND_ACC, 16'h8000, 16'h8000), 1'b0, '0);
		r = '0;
		r.rms_error = 16'h8000; r.mean_value = 16'h8000;
		r.min_value = 16'h8000; r.max_value = 16'h8000; r.sample_count = 24'd1;
		add_row(mk(rvstat_pkg::KIND_REPORT, 16'h0, 16'h0), 1'b1, r);
		add_row(mk(rvstat_pkg::KIND_ACC, 16'h7FFF, 16'h7FFF), 1'b0, '0);
		add_row(mk(rvstat_pkg::KIND_ACC, 16'h8000, 16'hFFFF), 1'b0, '0);
		add_row(mk(rvstat_pkg::KIND_ACC, 16'h0000, 16'h0001), 1'b0, '0);
		add_row(mk(rvstat_pkg::KIND_REPORT, 16'hFFFF, 16'hFFFF), 1'b0, '0);
		add_row(mk(rvstat_pkg::KIND_ACC, 16'hFFFF, 16'h0000), 1'b0, '0);
		add_row(mk(rvstat_pkg::KIND_ACC, 16'hFFFE, 16'h5555), 1'b0, '0);
		add_row(mk(rvstat_pkg::KIND_ACC, 16'hFFFD, 16'hAAAA), 1'b0, '0);
		add_row(mk(rvstat_pkg::KIND_REPORT, 16'h0, 16'h0), 1'b0, '0);
		// constant values give zero deviation
		add_row(mk(rvstat_pkg::KIND_ACC, 16'h0100, 16'h0100), 1'b0, '0);
		add_row(mk(rvstat_pkg::KIND_ACC, 16'h0100, 16'hFF00), 1'b0, '0);
		add_row(mk(rvstat_pkg::KIND_REPORT, 16'h0, 16'h0), 1'b0, '0);
		r = '0;
		r.empty_res = 1'b1;
		add_row(mk(rvstat_pkg::KIND_REPORT, 16'h0, 16'h0), 1'b1, r);
		// back-to-back reports fill the queue
		for (int i = 0; i < 4; i++)
			add_row(mk(rvstat_pkg::KIND_REPORT, 16'h0, 16'h0), 1'b0, '0);

		foreach (dir_rows[i]) begin
			send(dir_rows[i].item);
			if (dir_rows[i].known && report_q.size() != 0 &&
					report_q[$] !== dir_rows[i].res) begin
				$display("%0t model mismatch: expected %p actual %p",
					$time, dir_rows[i].res, report_q[$]);
				errors++;
			end
		end

		// random sample streams ending in a report, with stray reports as noise
		sent = 0;
		while (sent < 1800) begin
			burst = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 40);
			for (int i = 0; i < burst; i++) begin
				it = mk(rvstat_pkg::KIND_ACC, 16'($urandom), 16'($urandom));
				case ($urandom_range(0, 5))
					0: it.q_value = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
					1: it.q_value = 16'($urandom_range(0, 511) - 256);
					default: ;
				endcase
				send(it);
			end
			send(mk(rvstat_pkg::KIND_REPORT, 16'($urandom), 16'($urandom)));
			sent += burst + 1;
			if (sent > 900 && sent < 950) begin
				// hold off until every report has been read
				push <= 1'b0;
				@(posedge clk);
				while (report_q.size() != 0) @(posedge clk);
			end
		end

		push <= 1'b0;
		while (report_q.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
